/* sv/integer_square_root_core_macros.svh */
// Assertion macros shared by the integer square root core.
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef INTEGER_SQUARE_ROOT_CORE_MACROS_SVH
`define INTEGER_SQUARE_ROOT_CORE_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ISQRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ISQRT_ASSERT_NEVER(lbl, expr, msg) \
  `ISQRT_ASSERT(lbl, !(expr), msg)

`endif

/* sv/isqrt_pkg.sv */
`timescale 1ns / 1ps

package isqrt_pkg;

  // Default radicand width.
  localparam int unsigned RadicandBitsDefault = 31;

  // Width rounded up to whole bytes, as used for the stream data buses.
  function automatic int unsigned byte_width(input int unsigned bits);
    return ((bits + 7) / 8) * 8;
  endfunction

  // Number of root bits, one per pipeline stage.
  function automatic int unsigned root_width(input int unsigned bits);
    return (bits + 1) / 2;
  endfunction

endpackage

/* sv/integer_square_root_core.sv */
`timescale 1ns / 1ps

// Channel   | Dir | Beat contents (lowest bit first)
// s_axis    | in  | tdata: radicand (RADICAND_BITS), zero fill to whole bytes
// m_axis    | out | tdata: root ((RADICAND_BITS+1)/2 bits), zero fill to whole bytes
//
// One beat enters per cycle while s_axis_tready is high; the root is built
// in the stage pipeline, one root bit being settled per stage.
// Reset clears only the stage valid bits; the payload registers are not reset.
// Back-pressure moves up the pipeline through per-stage enables, so empty
// stages keep filling while the output waits and no beat is lost or repeated.
module integer_square_root_core #(
  parameter int unsigned RADICAND_BITS = isqrt_pkg::RadicandBitsDefault
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              s_axis_tvalid,
  output logic                                              s_axis_tready,
  // radicand [RADICAND_BITS-1:0], zeros above
  input  logic [isqrt_pkg::byte_width(RADICAND_BITS)-1:0]   s_axis_tdata,
  output logic                                              m_axis_tvalid,
  input  logic                                              m_axis_tready,
  // root [(RADICAND_BITS+1)/2-1:0], zeros above
  output logic [isqrt_pkg::byte_width((RADICAND_BITS+1)/2)-1:0] m_axis_tdata
);

  import isqrt_pkg::*;

  `include "integer_square_root_core_macros.svh"

  localparam int unsigned RootBits = root_width(RADICAND_BITS);
  localparam int unsigned PadBits  = 2 * RootBits;
  localparam int unsigned RemBits  = RootBits + 2;
  localparam int unsigned OutBits  = byte_width(RootBits);

  logic [PadBits-1:0]   rad_in;
  logic                 en_w   [RootBits];
  logic                 vld_w  [RootBits];
  logic [PadBits-1:0]   rad_w  [RootBits];
  logic [RemBits-1:0]   rem_w  [RootBits];
  logic [RootBits-1:0]  root_w [RootBits];
  logic [RemBits-1:0]   last_bound;
  logic                 last_over;

  // Radicand widened to an even number of bits.
  assign rad_in = PadBits'(s_axis_tdata[RADICAND_BITS-1:0]);

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en_w[RootBits-1] = !vld_w[RootBits-1] || m_axis_tready;
    for (int k = RootBits - 2; k >= 0; k--) begin
      en_w[k] = !vld_w[k] || en_w[k+1];
    end
  end

  // One stage per root bit, most significant first.
  for (genvar k = 0; k < RootBits; k++) begin : g_stage
    if (k == 0) begin : g_first
      isqrt_stage #(.RootBits(RootBits)) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en_w[k]),
        .vld_i  (s_axis_tvalid),
        .rad_i  (rad_in),
        .rem_i  ('0),
        .root_i ('0),
        .vld_o  (vld_w[k]),
        .rad_o  (rad_w[k]),
        .rem_o  (rem_w[k]),
        .root_o (root_w[k])
      );
    end else begin : g_next
      isqrt_stage #(.RootBits(RootBits)) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en_w[k]),
        .vld_i  (vld_w[k-1]),
        .rad_i  (rad_w[k-1]),
        .rem_i  (rem_w[k-1]),
        .root_i (root_w[k-1]),
        .vld_o  (vld_w[k]),
        .rad_o  (rad_w[k]),
        .rem_o  (rem_w[k]),
        .root_o (root_w[k])
      );
    end
  end

  // The last stage is the output register.
  assign s_axis_tready = en_w[0];
  assign m_axis_tvalid = vld_w[RootBits-1];
  assign m_axis_tdata  = OutBits'(root_w[RootBits-1]);

  // A correct final remainder never exceeds twice the root.
  assign last_bound = {1'b0, root_w[RootBits-1], 1'b0};
  assign last_over  = (rem_w[RootBits-1] > last_bound);

  // Pipeline checks.
  `ISQRT_ASSERT(a_ready_follows_out, m_axis_tready |-> s_axis_tready, "input stalled on drain")
  `ISQRT_ASSERT(a_accept_lands, (s_axis_tvalid && s_axis_tready) |=> vld_w[0], "beat lost")
  `ISQRT_ASSERT(a_stall_holds, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "dropped")
  `ISQRT_ASSERT_NEVER(a_rem_bound, m_axis_tvalid && last_over, "final remainder too big")

endmodule

/* sv/isqrt_stage.sv */
`timescale 1ns / 1ps

// One restoring step of the digit-by-digit square root: brings down the next
// two radicand bits, tries the digit one, and registers the partial root.
module isqrt_stage #(
  parameter int unsigned RootBits = isqrt_pkg::root_width(isqrt_pkg::RadicandBitsDefault)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [2*RootBits-1:0]   rad_i,
  input  logic [RootBits+1:0]     rem_i,
  input  logic [RootBits-1:0]     root_i,
  output logic                    vld_o,
  output logic [2*RootBits-1:0]   rad_o,
  output logic [RootBits+1:0]     rem_o,
  output logic [RootBits-1:0]     root_o
);

  import isqrt_pkg::*;

  localparam int unsigned PadBits = 2 * RootBits;
  localparam int unsigned RemBits = RootBits + 2;

  logic [RemBits+1:0]   rem_x;
  logic [RemBits+1:0]   trial;
  logic [RemBits+1:0]   diff;
  logic                 take;
  logic [RootBits:0]    root_x;
  logic [PadBits+1:0]   rad_x;

  logic                 vld_q;
  logic [PadBits-1:0]   rad_q, rad_d;
  logic [RemBits-1:0]   rem_q, rem_d;
  logic [RootBits-1:0]  root_q, root_d;

  // Trial subtract of 4*root + 1 from the extended remainder.
  always_comb begin
    rem_x  = {rem_i, rad_i[PadBits-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    diff   = rem_x - trial;
    take   = (rem_x >= trial);
    root_x = {root_i, take};
    rad_x  = {rad_i, 2'b00};
    rem_d  = take ? diff[RemBits-1:0] : rem_x[RemBits-1:0];
    root_d = root_x[RootBits-1:0];
    rad_d  = rad_x[PadBits-1:0];
  end

  // Valid bit with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Payload registers load whenever the stage advances.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign vld_o  = vld_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import isqrt_pkg::*;

  localparam int unsigned RadBits = RadicandBitsDefault;
  localparam int unsigned InW     = byte_width(RadBits);
  localparam int unsigned RootW   = root_width(RadBits);
  localparam int unsigned OutW    = byte_width(RootW);
  // Pipeline depth, one stage per root bit.
  localparam int unsigned Latency = RootW;
  localparam int unsigned MaxShown = 10;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  // radicand [RadBits-1:0], padding above
  logic [InW-1:0]  s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  // root [RootW-1:0], padding above
  logic [OutW-1:0] m_axis_tdata;

  // Roots still owed by the block, oldest first.
  logic [OutW-1:0] pending_roots [$];
  logic [OutW-1:0] root_want;
  int unsigned     fault_count;

  // Idle odds in percent, and a long receiver hold-off request in cycles.
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     hold_req;
  int unsigned     hold_left;

  integer_square_root_core #(
    .RADICAND_BITS(RadBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Floor square root, restoring method, one root bit per pass. Bits above the
  // radicand width are dropped first.
  function automatic logic [OutW-1:0] floor_root(input logic [InW-1:0] word);
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] digit;
    rem = 64'(word[RadBits-1:0]);
    acc = '0;
    for (int k = RootW - 1; k >= 0; k--) begin
      digit = 64'd1 << (2 * k);
      if (rem >= acc + digit) begin
        rem = rem - (acc + digit);
        acc = (acc >> 1) + digit;
      end else begin
        acc = acc >> 1;
      end
    end
    return OutW'(acc[RootW-1:0]);
  endfunction

  // Radicand mix: wide random values, exact squares and their neighbors,
  // random bit lengths and small values; now and then the padding bit is set.
  function automatic logic [InW-1:0] pick_radicand();
    longint unsigned side;
    logic [InW-1:0]  word;
    int unsigned     len;
    side = longint'($urandom_range(46340));
    case ($urandom_range(5))
      0: word = InW'($urandom) & InW'((64'd1 << RadBits) - 1);
      1: word = InW'(side * side);
      2: word = InW'(side * side - ((side == 0) ? 0 : 1));
      3: begin
        len  = $urandom_range(1, RadBits);
        word = InW'($urandom) & InW'((64'd1 << len) - 1);
      end
      4: word = InW'($urandom_range(300));
      default: begin
        if (side == 46340) side = 46339;
        word = InW'(side * side + longint'($urandom_range(2 * int'(side))));
      end
    endcase
    if ($urandom_range(7) == 0) word[InW-1] = 1'b1;
    return word;
  endfunction

  function automatic void note_fault(input string what, input logic [OutW-1:0] want,
                                     input logic [OutW-1:0] got);
    if (fault_count < MaxShown)
      $display("%0t: %s: expected root %0d, got %0d", $realtime, what, want, got);
    fault_count++;
  endfunction

  // Offers one beat, after random idle cycles, and books its root on acceptance.
  // Returns at the falling edge after the handshake with tvalid still high.
  task automatic send_radicand(input logic [InW-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = word;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_roots.push_back(floor_root(word));
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every booked root has come out.
  task automatic wait_for_roots();
    s_axis_tvalid = 1'b0;
    while (pending_roots.size() != 0) @(negedge clk_i);
  endtask

  // Corner radicands: zero, tiny values, squares and their neighbors, the
  // largest radicand, the padding bit alone and with data, bit patterns.
  task automatic test_corners();
    send_radicand(32'd0);
    send_radicand(32'd1);
    send_radicand(32'd2);
    send_radicand(32'd3);
    send_radicand(32'd4);
    send_radicand(32'd24);
    send_radicand(32'd25);
    send_radicand(32'd26);
    send_radicand(32'h3FFF_FFFF);
    send_radicand(32'h4000_0000);
    send_radicand(32'd2147395599);
    send_radicand(32'd2147395600);
    send_radicand(32'h7FFF_FFFF);
    send_radicand(32'h8000_0000);
    send_radicand(32'h8000_0019);
    send_radicand(32'hFFFF_FFFF);
    send_radicand(32'h5555_5555);
    send_radicand(32'h2AAA_AAAA);
    send_radicand(32'h0000_FFFF);
    wait_for_roots();
  endtask

  task automatic test_random(input int unsigned count, input int unsigned send_pct,
                             input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_radicand(pick_radicand());
    wait_for_roots();
  endtask

  // The receiver holds off long enough for the pipeline to fill and push back
  // on the sender, which keeps offering beats the whole time.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 300;
    repeat (80) send_radicand(pick_radicand());
    wait_for_roots();
  endtask

  // Receiver side, with its own hold-off counter.
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Each root beat is checked against the oldest booked root.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_roots.size() == 0) begin
        note_fault("root beat with nothing pending", '0, m_axis_tdata);
      end else begin
        root_want = pending_roots.pop_front();
        if (m_axis_tdata !== root_want) note_fault("root mismatch", root_want, m_axis_tdata);
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    fault_count   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_corners();
    test_random(280, 22, 64);
    test_random(280, 64, 22);
    test_random(290, 0, 0);
    test_output_stall();

    // Let any stray beat show up before the verdict.
    repeat (Latency + 20) @(negedge clk_i);
    if (pending_roots.size() != 0) begin
      $display("%0d roots never arrived", pending_roots.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
